[hdl/prefix_varint_decoder_unit_assert.svh]
// Assertion macros for the prefix varint decoder.
// They expand to nothing when SYNTHESIS is defined.
`ifndef PREFIX_VARINT_DECODER_UNIT_ASSERT_SVH
`define PREFIX_VARINT_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define PVD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// cond must never be true outside reset
`define PVD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PVD_ASSERT(lbl, clk, rstn, prop, msg)
`define PVD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[hdl/pvd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pvd_pkg;

  localparam int unsigned ValueW = 63;
  localparam int unsigned AccW   = 64;
  // extra byte count that selects the full eight-byte form
  localparam logic [3:0] FullExtra = 4'd8;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TRUNC    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } byte_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } dec_out_t;

  // count of trailing one bits, 0 to 8
  function automatic logic [3:0] trailing_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/pvd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// byte stream channel
interface pvd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// decoded number channel
interface pvd_result_if;
  logic        valid;
  logic        ready;
  logic [62:0] value;
  logic [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

[hdl/prefix_varint_decoder_unit.sv]
// Path: a byte taken into the input register is decoded from there, and its
//   result (if any) is registered in the result register that drives result_o.
// Throughput: one byte per cycle; the input register, the decode pass and the
//   result register each move one transfer per cycle, stalled only by result_o.
// Reset: rst_ni is asynchronous, active low; it empties both registers and
//   returns the decoder to idle, awaiting the first byte of a number.
`timescale 1ns / 1ps
`default_nettype none

`include "prefix_varint_decoder_unit_assert.svh"

module prefix_varint_decoder_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  pvd_byte_if.sink      byte_i,
  pvd_result_if.source  result_o
);

  // Three parts: input register, decoder with its number state, result
  // register. The decoder works only when the result register has room, so a
  // held result stalls the byte sitting in the input register, and that in
  // turn drops byte_i.ready once the input register is occupied.

  logic                item_valid;
  pvd_pkg::byte_item_t item;
  pvd_pkg::dec_out_t   dec_out;
  logic                out_room;
  logic                advance;

  // one byte moves through the decoder per cycle while there is room
  assign advance = item_valid && out_room;

  pvd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Trailing ones of a first byte give the extra byte count; later bytes are
  // OR-ed into their byte slot of the accumulator, and the last one also
  // drives the final shift and the overflow check in the same pass.
  pvd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item),
    .dec_o  (dec_out)
  );

  pvd_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .dec_i     (dec_out),
    .room_o    (out_room),
    .result_o  (result_o)
  );

  // a truncation result only comes from a byte marked as the last one
  `PVD_ASSERT(a_trunc_needs_end, clk_i, rst_ni,
    (dec_out.valid && dec_out.result.status == pvd_pkg::STATUS_TRUNC) |-> item.end_of_data,
    "truncation reported on a byte not marked last")

  // an error result carries a zero value
  `PVD_ASSERT_NEVER(a_err_value_zero, clk_i, rst_ni,
    result_o.valid && result_o.status != pvd_pkg::STATUS_OK && result_o.value != '0,
    "error result with non-zero value")

  // a waiting byte is not lost while the decoder is stalled
  `PVD_ASSERT(a_item_held, clk_i, rst_ni,
    (item_valid && !advance) |=> item_valid,
    "input byte dropped while stalled")

  // the decoder only produces a result when it fires
  `PVD_ASSERT_NEVER(a_result_without_fire, clk_i, rst_ni,
    dec_out.valid && !advance,
    "decoder result without a byte transfer")

endmodule

`default_nettype wire

[hdl/pvd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one byte until the decoder takes it.
module pvd_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pvd_byte_if.sink                 byte_i,
  input  wire logic                advance_i,
  output      logic                item_valid_o,
  output      pvd_pkg::byte_item_t item_o
);

  logic                valid_q;
  logic                valid_d;
  pvd_pkg::byte_item_t item_q;
  logic                load;

  assign byte_i.ready = !valid_q || advance_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte   <= byte_i.data_byte;
      item_q.end_of_data <= byte_i.end_of_data;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[hdl/pvd_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

// Number state and single-pass decode of one byte.
module pvd_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire pvd_pkg::byte_item_t item_i,
  output      pvd_pkg::dec_out_t   dec_o
);

  logic                       collecting_q, collecting_d;
  logic [3:0]                 extra_q, extra_d;
  logic [3:0]                 recv_q, recv_d;
  logic [pvd_pkg::AccW-1:0]   acc_q, acc_d;
  logic [3:0]                 first_ones;
  logic [3:0]                 recv_inc;
  logic [2:0]                 slot;
  logic                       full_width;
  logic [pvd_pkg::AccW-1:0]   acc_merged;
  logic [pvd_pkg::AccW-1:0]   value_full;

  always_comb begin
    first_ones = pvd_pkg::trailing_ones(item_i.data_byte);
    recv_inc   = recv_q + 4'd1;
    full_width = (extra_q == pvd_pkg::FullExtra);
    // full form starts at byte 0, short form after the first byte
    slot       = full_width ? recv_q[2:0] : recv_q[2:0] + 3'd1;
    for (int k = 0; k < 8; k++) begin
      acc_merged[8*k +: 8] = acc_q[8*k +: 8] | ((slot == 3'(k)) ? item_i.data_byte : 8'h00);
    end
    value_full = full_width ? acc_merged : ((acc_merged >> extra_q[2:0]) >> 1);
  end

  always_comb begin
    collecting_d         = collecting_q;
    extra_d              = extra_q;
    recv_d               = recv_q;
    acc_d                = acc_q;
    dec_o.valid          = 1'b0;
    dec_o.result.value   = '0;
    dec_o.result.status  = pvd_pkg::STATUS_OK;

    if (fire_i) begin
      if (!collecting_q) begin
        if (first_ones == 4'd0) begin
          dec_o.valid        = 1'b1;
          dec_o.result.value = {56'd0, item_i.data_byte[7:1]};
        end else if (item_i.end_of_data) begin
          dec_o.valid         = 1'b1;
          dec_o.result.status = pvd_pkg::STATUS_TRUNC;
        end else begin
          collecting_d = 1'b1;
          extra_d      = first_ones;
          recv_d       = 4'd0;
          acc_d        = (first_ones == pvd_pkg::FullExtra) ? '0 : {56'd0, item_i.data_byte};
        end
      end else begin
        if (recv_inc >= extra_q) begin
          dec_o.valid = 1'b1;
          if (value_full[pvd_pkg::AccW-1]) begin
            dec_o.result.status = pvd_pkg::STATUS_OVERFLOW;
          end else begin
            dec_o.result.value = value_full[pvd_pkg::ValueW-1:0];
          end
        end else if (item_i.end_of_data) begin
          dec_o.valid         = 1'b1;
          dec_o.result.status = pvd_pkg::STATUS_TRUNC;
        end else begin
          acc_d  = acc_merged;
          recv_d = recv_inc;
        end
      end

      // any result ends the number
      if (dec_o.valid) begin
        collecting_d = 1'b0;
        extra_d      = 4'd0;
        recv_d       = 4'd0;
        acc_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      extra_q      <= 4'd0;
      recv_q       <= 4'd0;
      acc_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      extra_q      <= extra_d;
      recv_q       <= recv_d;
      acc_q        <= acc_d;
    end
  end

endmodule

`default_nettype wire

[hdl/pvd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds a finished number until the sink takes it.
module pvd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire pvd_pkg::dec_out_t dec_i,
  output      logic              room_o,
  pvd_result_if.source           result_o
);

  logic             valid_q;
  logic             valid_d;
  pvd_pkg::result_t result_q;
  logic             load;

  assign room_o = !valid_q || result_o.ready;
  assign load   = advance_i && dec_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (room_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= dec_i.result;
    end
  end

  assign result_o.valid  = valid_q;
  assign result_o.value  = result_q.value;
  assign result_o.status = result_q.status;

endmodule

`default_nettype wire

[bench/tb_prefix_varint_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_prefix_varint_decoder_unit;

  localparam int unsigned NumItems   = 1100;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned HoldCycles = 400;

  localparam pvd_pkg::result_t NoNumber = '{'0, pvd_pkg::STATUS_OK};

  typedef struct {
    pvd_pkg::byte_item_t item;
    bit                  typed;   // expectation written into the row
    bit                  has_res;
    pvd_pkg::result_t    res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pvd_byte_if   byte_if ();
  pvd_result_if res_if ();

  prefix_varint_decoder_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // decoder state as predicted
  logic        dec_collecting;
  logic [3:0]  dec_extra;
  logic [3:0]  dec_rcvd;
  logic [63:0] dec_acc;

  pvd_pkg::result_t pending_numbers[$];
  int unsigned      mismatch_cnt;
  int unsigned      numbers_checked;
  int unsigned      items_sent;
  bit               mid_pause_done;

  // directed: extremes, truncation on first and extra bytes, overflow
  stim_row_t dir_rows [25] = '{
    '{'{8'h00, 1'b0}, 1'b1, 1'b1, '{63'd0, pvd_pkg::STATUS_OK}},
    '{'{8'hFE, 1'b1}, 1'b1, 1'b1, '{63'd127, pvd_pkg::STATUS_OK}},
    '{'{8'h01, 1'b1}, 1'b1, 1'b1, '{63'd0, pvd_pkg::STATUS_TRUNC}},
    '{'{8'h03, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h55, 1'b1}, 1'b1, 1'b1, '{63'd0, pvd_pkg::STATUS_TRUNC}},
    '{'{8'h01, 1'b0}, 1'b0, 1'b0, NoNumber},
    '{'{8'hFF, 1'b1}, 1'b0, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h7F, 1'b0}, 1'b1, 1'b1, '{63'h7FFF_FFFF_FFFF_FFFF, pvd_pkg::STATUS_OK}},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, NoNumber},
    '{'{8'h80, 1'b1}, 1'b1, 1'b1, '{63'd0, pvd_pkg::STATUS_OVERFLOW}}
  };

  function automatic void clear_number();
    dec_collecting = 1'b0;
    dec_extra      = 4'd0;
    dec_rcvd       = 4'd0;
    dec_acc        = 64'd0;
  endfunction

  function automatic pvd_pkg::result_t close_number();
    logic [63:0]      v;
    pvd_pkg::result_t r;
    v = dec_acc;
    if (dec_extra != pvd_pkg::FullExtra) begin
      v = v >> (int'(dec_extra[2:0]) + 1);
    end
    if (v[63]) begin
      r = '{'0, pvd_pkg::STATUS_OVERFLOW};
    end else begin
      r = '{v[62:0], pvd_pkg::STATUS_OK};
    end
    clear_number();
    return r;
  endfunction

  // returns 1 when the byte finishes a number or ends it early
  function automatic bit decode_step(input pvd_pkg::byte_item_t it,
                                     output pvd_pkg::result_t r);
    logic [3:0]  n;
    int unsigned sh;
    r = '{'0, pvd_pkg::STATUS_TRUNC};
    if (!dec_collecting) begin
      n = 4'd0;
      while (n < pvd_pkg::FullExtra && it.data_byte[n[2:0]]) begin
        n++;
      end
      dec_extra = n;
      dec_rcvd  = 4'd0;
      dec_acc   = (n == pvd_pkg::FullExtra) ? 64'd0 : {56'd0, it.data_byte};
      if (n == 4'd0) begin
        r = close_number();
        return 1'b1;
      end
      if (it.end_of_data) begin
        clear_number();
        return 1'b1;
      end
      dec_collecting = 1'b1;
      return 1'b0;
    end
    // extra bytes are pure data
    if (dec_extra == pvd_pkg::FullExtra) begin
      sh = 8 * int'(dec_rcvd[2:0]);
    end else begin
      sh = 8 * (int'(dec_rcvd[2:0]) + 1);
    end
    if (sh < 64) begin
      dec_acc = dec_acc | ({56'd0, it.data_byte} << sh);
    end
    dec_rcvd++;
    if (dec_rcvd >= dec_extra) begin
      r = close_number();
      return 1'b1;
    end
    if (it.end_of_data) begin
      clear_number();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  // offer one byte from a rising edge; returns at the edge that takes it
  task automatic send_byte(input pvd_pkg::byte_item_t it, input bit typed,
                           input bit typed_has, input pvd_pkg::result_t typed_res);
    pvd_pkg::result_t r;
    bit               got;
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= it.data_byte;
    byte_if.end_of_data <= it.end_of_data;
    do @(negedge clk_i); while (!byte_if.ready);
    got = decode_step(it, r);
    if (typed) begin
      if (typed_has) pending_numbers.push_back(typed_res);
    end else if (got) begin
      pending_numbers.push_back(r);
    end
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic sender_gap();
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if ((items_sent / 128) % 3 == 1 || r < 55) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      byte_if.valid       <= 1'b0;
      byte_if.data_byte   <= 8'($urandom);
      byte_if.end_of_data <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eod);
    send_byte('{b, eod}, 1'b0, 1'b0, NoNumber);
    sender_gap();
  endtask

  // sender stops until every pending number has come back
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_numbers.size() != 0) @(posedge clk_i);
  endtask

  // well-formed number, sometimes cut short or flagged last on its final byte
  task automatic send_number();
    int unsigned n;
    int unsigned mode;
    int unsigned cut;
    logic [7:0]  b;
    n    = $urandom_range(0, 8);
    mode = $urandom_range(0, 9);
    cut  = n + 1;
    if (mode == 0 && n > 0) cut = $urandom_range(0, n - 1);
    if (mode == 1) cut = n;
    for (int k = 0; k <= n; k++) begin
      if (k == 0) begin
        if (n == 8) begin
          b = 8'hFF;
        end else begin
          b = 8'($urandom) << (n + 1);
          b = b | ((8'd1 << n) - 8'd1);
        end
      end else if (n == 8 && k == 8 && $urandom_range(0, 3) != 0) begin
        b = 8'($urandom_range(0, 127));  // mostly in range, some overflow
      end else begin
        b = 8'($urandom);
      end
      push_byte(b, k == cut);
      if (k == cut) break;
    end
  endtask

  // raw bytes, then a byte flagged last so the decoder is idle again
  task automatic send_noise();
    int unsigned cnt;
    cnt = $urandom_range(1, 3);
    repeat (cnt) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
    push_byte(8'($urandom), 1'b1);
  endtask

  always @(negedge clk_i) begin : number_check
    pvd_pkg::result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      numbers_checked++;
      if (pending_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected number value=%0h status=%0d",
                                  res_if.value, res_if.status));
      end else begin
        want = pending_numbers.pop_front();
        if (res_if.value !== want.value) begin
          report_mismatch($sformatf("value %0h, want %0h", res_if.value, want.value));
        end
        if (res_if.status !== want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", res_if.status, want.status));
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned cyc;
    int unsigned r;
    bit          held;
    res_if.ready = 1'b0;
    stall_left   = 0;
    cyc          = 0;
    held         = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      cyc++;
      // one long hold-off: decoder fills and must stall the byte side
      if (!held && numbers_checked >= 100) begin
        held       = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if ((cyc / 700) % 3 != 2) begin
          if (r < 25) begin
            stall_left = $urandom_range(1, 3);
          end else if (r < 27) begin
            stall_left = $urandom_range(10, 40);
          end
        end
      end
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb_prefix_varint_decoder_unit: done, errors");
    $finish;
  end

  initial begin : stimulus
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = 8'd0;
    byte_if.end_of_data = 1'b0;
    mismatch_cnt        = 0;
    numbers_checked     = 0;
    items_sent          = 0;
    mid_pause_done      = 1'b0;
    clear_number();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
      sender_gap();
    end
    wait_drained();

    while (items_sent < NumItems) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_number();
      end
      if (!mid_pause_done && items_sent >= NumItems / 2) begin
        mid_pause_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_prefix_varint_decoder_unit: done, clean");
    end else begin
      $display("tb_prefix_varint_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule
